@@ sv/lrd_pkg.sv @@
`timescale 1ns / 1ps

package lrd_pkg;

    // field widths
    localparam int LEVEL_BITS = 16;
    localparam int RAMP_BITS  = 24;
    localparam int TIME_BITS  = 32;

    // width of the diff * elapsed product, also the divider's working word
    localparam int PROD_BITS = LEVEL_BITS + RAMP_BITS;

    // divider step counter, one quotient bit per step
    localparam int CNT_BITS = $clog2(LEVEL_BITS);

    // ramp length after reset, saturated to the field width
    localparam logic [RAMP_BITS-1:0] RESET_RAMP_LEN =
        (RAMP_BITS >= 10) ? RAMP_BITS'(1000) : '1;

    // transaction kinds
    localparam logic KIND_STEP  = 1'b0;
    localparam logic KIND_CLEAR = 1'b1;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_MUL,
        ST_DIV,
        ST_FORM,
        ST_WRITE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture the input transaction
        logic eval;      // apply clear or new target, compute elapsed time
        logic mul;       // compare elapsed time, form the product
        logic div_step;  // one restoring divide step
        logic form;      // build the level from the quotient
        logic push;      // move the result into the output register
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_clear;  // captured transaction is a clear
        logic finished;  // elapsed time has reached the ramp length
    } status_t;

endpackage

@@ sv/lrd_ctrl.sv @@
`timescale 1ns / 1ps

module lrd_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  lrd_pkg::status_t status,
    output lrd_pkg::cmd_t    cmd
);

    lrd_pkg::state_t state_reg;
    lrd_pkg::state_t state_next;
    logic [lrd_pkg::CNT_BITS-1:0] cnt_reg;
    logic [lrd_pkg::CNT_BITS-1:0] cnt_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic slot_free;

    // output slot is free when empty or being drained this cycle
    assign slot_free = !out_valid_reg || out_ready;

    // state, step counter and output valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lrd_pkg::ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            lrd_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = lrd_pkg::ST_EVAL;
                end
            end
            lrd_pkg::ST_EVAL:
            begin
                cmd.eval = 1'b1;
                if (status.is_clear)
                begin
                    state_next = lrd_pkg::ST_WRITE;
                end
                else
                begin
                    state_next = lrd_pkg::ST_MUL;
                end
            end
            lrd_pkg::ST_MUL:
            begin
                cmd.mul  = 1'b1;
                cnt_next = '0;
                if (status.finished)
                begin
                    state_next = lrd_pkg::ST_WRITE;
                end
                else
                begin
                    state_next = lrd_pkg::ST_DIV;
                end
            end
            lrd_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == lrd_pkg::CNT_BITS'(lrd_pkg::LEVEL_BITS - 1))
                begin
                    state_next = lrd_pkg::ST_FORM;
                end
            end
            lrd_pkg::ST_FORM:
            begin
                cmd.form   = 1'b1;
                state_next = lrd_pkg::ST_WRITE;
            end
            lrd_pkg::ST_WRITE:
            begin
                if (slot_free)
                begin
                    cmd.push   = 1'b1;
                    state_next = lrd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lrd_pkg::ST_IDLE;
            end
        endcase
    end

    // output valid follows push and drain
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.push)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

@@ sv/lrd_datapath.sv @@
`timescale 1ns / 1ps

module lrd_datapath
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  lrd_pkg::cmd_t                  cmd,
    output lrd_pkg::status_t               status,
    input  logic                           kind,
    input  logic [lrd_pkg::LEVEL_BITS-1:0] target_level,
    input  logic [lrd_pkg::RAMP_BITS-1:0]  ramp_ms,
    input  logic [lrd_pkg::TIME_BITS-1:0]  now_ms,
    output logic [lrd_pkg::LEVEL_BITS-1:0] level,
    output logic                           ramp_done
);

    // captured transaction
    logic                           kind_reg;
    logic [lrd_pkg::LEVEL_BITS-1:0] tgt_in_reg;
    logic [lrd_pkg::RAMP_BITS-1:0]  len_in_reg;
    logic [lrd_pkg::TIME_BITS-1:0]  now_in_reg;

    // ramp state
    logic [lrd_pkg::LEVEL_BITS-1:0] present_level_reg;
    logic [lrd_pkg::LEVEL_BITS-1:0] start_level_reg;
    logic [lrd_pkg::TIME_BITS-1:0]  start_time_reg;
    logic [lrd_pkg::LEVEL_BITS-1:0] ramp_target_reg;
    logic [lrd_pkg::RAMP_BITS-1:0]  ramp_length_reg;

    // working registers
    logic [lrd_pkg::TIME_BITS-1:0]  elapsed_reg;
    logic [lrd_pkg::PROD_BITS-1:0]  rq_reg;
    logic                           down_reg;
    logic [lrd_pkg::LEVEL_BITS-1:0] result_reg;
    logic                           result_done_reg;
    logic [lrd_pkg::LEVEL_BITS-1:0] level_out_reg;
    logic                           done_out_reg;

    logic                           target_changed;
    logic                           is_clear;
    logic                           finished;
    logic                           down;
    logic [lrd_pkg::LEVEL_BITS-1:0] diff;
    logic [lrd_pkg::PROD_BITS-1:0]  product;
    logic [lrd_pkg::RAMP_BITS:0]    trial;
    logic                           trial_ge;
    logic [lrd_pkg::RAMP_BITS-1:0]  rem_next;
    logic [lrd_pkg::LEVEL_BITS-1:0] quotient;

    assign target_changed = (tgt_in_reg != ramp_target_reg);
    assign is_clear       = (kind_reg == lrd_pkg::KIND_CLEAR);
    assign finished       = (elapsed_reg >= lrd_pkg::TIME_BITS'(ramp_length_reg));

    // magnitude and direction of the ramp
    assign down = (ramp_target_reg < start_level_reg);
    assign diff = down ? (start_level_reg - ramp_target_reg)
                       : (ramp_target_reg - start_level_reg);
    assign product = lrd_pkg::PROD_BITS'(diff) *
                     lrd_pkg::PROD_BITS'(elapsed_reg[lrd_pkg::RAMP_BITS-1:0]);

    // restoring divide step: remainder in the upper bits, quotient shifts in below
    assign trial    = {rq_reg[lrd_pkg::PROD_BITS-1:lrd_pkg::LEVEL_BITS],
                       rq_reg[lrd_pkg::LEVEL_BITS-1]};
    assign trial_ge = (trial >= {1'b0, ramp_length_reg});
    assign rem_next = trial_ge ? lrd_pkg::RAMP_BITS'(trial - {1'b0, ramp_length_reg})
                               : trial[lrd_pkg::RAMP_BITS-1:0];
    assign quotient = rq_reg[lrd_pkg::LEVEL_BITS-1:0];

    // input capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg   <= kind;
            tgt_in_reg <= target_level;
            len_in_reg <= ramp_ms;
            now_in_reg <= now_ms;
        end
    end

    // ramp state: clear, new target latch, level update on push
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_level_reg <= '0;
            start_level_reg   <= '0;
            start_time_reg    <= '0;
            ramp_target_reg   <= '0;
            ramp_length_reg   <= lrd_pkg::RESET_RAMP_LEN;
        end
        else if (cmd.eval)
        begin
            if (is_clear)
            begin
                present_level_reg <= '0;
                start_level_reg   <= '0;
                start_time_reg    <= '0;
                ramp_target_reg   <= '0;
                ramp_length_reg   <= lrd_pkg::RESET_RAMP_LEN;
            end
            else if (target_changed)
            begin
                start_level_reg <= present_level_reg;
                start_time_reg  <= now_in_reg;
                ramp_target_reg <= tgt_in_reg;
                ramp_length_reg <= len_in_reg;
            end
        end
        else if (cmd.push)
        begin
            present_level_reg <= result_reg;
        end
    end

    // elapsed time, product, divider and result
    always_ff @(posedge clk)
    begin
        if (cmd.eval)
        begin
            elapsed_reg     <= target_changed ? '0 : (now_in_reg - start_time_reg);
            result_reg      <= '0;
            result_done_reg <= 1'b0;
        end
        if (cmd.mul)
        begin
            rq_reg          <= product;
            down_reg        <= down;
            result_reg      <= ramp_target_reg;
            result_done_reg <= finished;
        end
        if (cmd.div_step)
        begin
            rq_reg <= {rem_next, rq_reg[lrd_pkg::LEVEL_BITS-2:0], trial_ge};
        end
        if (cmd.form)
        begin
            result_reg <= down_reg ? (start_level_reg - quotient)
                                   : (start_level_reg + quotient);
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            level_out_reg <= result_reg;
            done_out_reg  <= result_done_reg;
        end
    end

    assign status.is_clear = is_clear;
    assign status.finished = finished;
    assign level           = level_out_reg;
    assign ramp_done       = done_out_reg;

endmodule

@@ sv/linear_ramp_dimmer.sv @@
`timescale 1ns / 1ps

// channel   handshake              payload
// -------   --------------------   -----------------------------------------
// input     in_valid / in_ready    kind, target_level, ramp_ms, now_ms
// output    out_valid / out_ready  level, ramp_done
//
// one transaction at a time; after input accept the result passes the states
// EVAL, WRITE on a clear, EVAL, MUL, WRITE when the ramp has finished and EVAL,
// MUL, DIV, FORM, WRITE while ramping, where the restoring divider retires one
// quotient bit per cycle in DIV; in_ready returns the cycle after the write.
// a stalled output holds the block in its write step; input is still taken while
// an earlier result waits. rst_n clears to level 0, target 0, ramp length 1000.

module linear_ramp_dimmer
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           kind,
    input  logic [lrd_pkg::LEVEL_BITS-1:0] target_level,
    input  logic [lrd_pkg::RAMP_BITS-1:0]  ramp_ms,
    input  logic [lrd_pkg::TIME_BITS-1:0]  now_ms,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [lrd_pkg::LEVEL_BITS-1:0] level,
    output logic                           ramp_done
);

    lrd_pkg::cmd_t    cmd;
    lrd_pkg::status_t status;

    // sequencer
    lrd_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // ramp state, multiplier and divider
    lrd_datapath u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .kind         (kind),
        .target_level (target_level),
        .ramp_ms      (ramp_ms),
        .now_ms       (now_ms),
        .level        (level),
        .ramp_done    (ramp_done)
    );

endmodule

@@ tb/sv/tb_linear_ramp_dimmer.sv @@
`timescale 1ns / 1ps

module tb_linear_ramp_dimmer;

    localparam logic KIND_STEP  = lrd_pkg::KIND_STEP;
    localparam logic KIND_CLEAR = lrd_pkg::KIND_CLEAR;

    localparam int IDLE_PCT      = 27;
    localparam int RANDOM_ITEMS  = 476;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_CYCLES  = 40;
    localparam int STALL_LIMIT   = 3000;
    localparam int REPORT_LIMIT  = 10;
    localparam int SCRIPT_ROWS   = 24;

    typedef struct {
        bit                             kind;
        logic [lrd_pkg::LEVEL_BITS-1:0] target;
        logic [lrd_pkg::RAMP_BITS-1:0]  ramp;
        logic [lrd_pkg::TIME_BITS-1:0]  now;
        bit                             typed;
        logic [lrd_pkg::LEVEL_BITS-1:0] lvl;
        bit                             done;
    } dim_cmd_t;

    typedef struct {
        logic [lrd_pkg::LEVEL_BITS-1:0] lvl;
        bit                             done;
    } dim_level_t;

    logic                           clk;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_ready;
    logic                           kind;
    logic [lrd_pkg::LEVEL_BITS-1:0] target_level;
    logic [lrd_pkg::RAMP_BITS-1:0]  ramp_ms;
    logic [lrd_pkg::TIME_BITS-1:0]  now_ms;
    logic                           out_valid;
    logic                           out_ready;
    logic [lrd_pkg::LEVEL_BITS-1:0] level;
    logic                           ramp_done;

    // predictor copy of the dimmer state
    logic [lrd_pkg::LEVEL_BITS-1:0] model_level;
    logic [lrd_pkg::LEVEL_BITS-1:0] model_start_level;
    logic [lrd_pkg::TIME_BITS-1:0]  model_start_time;
    logic [lrd_pkg::LEVEL_BITS-1:0] model_target;
    logic [lrd_pkg::RAMP_BITS-1:0]  model_length;

    dim_level_t expected_levels[$];
    dim_cmd_t   ramp_script[SCRIPT_ROWS];

    int  mismatches;
    int  items_sent;
    int  levels_seen;
    int  finished_seen;
    int  ramping_seen;
    int  clears_sent;
    int  quiet_cycles;
    bit  no_gaps;
    bit  hold_request;

    linear_ramp_dimmer uut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .target_level (target_level),
        .ramp_ms      (ramp_ms),
        .now_ms       (now_ms),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .level        (level),
        .ramp_done    (ramp_done)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // return the predictor to the reset state
    function automatic void clear_dimmer_state();
        model_level       = '0;
        model_start_level = '0;
        model_start_time  = '0;
        model_target      = '0;
        model_length      = lrd_pkg::RESET_RAMP_LEN;
    endfunction

    // next interpolated level for one accepted transaction
    function automatic dim_level_t next_dim_level(input dim_cmd_t cmd);
        dim_level_t                    res;
        logic [lrd_pkg::TIME_BITS-1:0] elapsed;
        logic [63:0]                   span;
        logic [63:0]                   stepped;
        if (cmd.kind == KIND_CLEAR)
        begin
            clear_dimmer_state();
            res.lvl  = '0;
            res.done = 1'b0;
            return res;
        end
        // a new target latches a fresh ramp from the present level
        if (cmd.target != model_target)
        begin
            model_target      = cmd.target;
            model_start_level = model_level;
            model_start_time  = cmd.now;
            model_length      = cmd.ramp;
        end
        elapsed = cmd.now - model_start_time;
        if (elapsed >= lrd_pkg::TIME_BITS'(model_length))
        begin
            model_level = model_target;
            res.done    = 1'b1;
        end
        else
        begin
            // truncate toward the start level
            if (model_target >= model_start_level)
            begin
                span        = 64'(model_target - model_start_level);
                stepped     = (span * 64'(elapsed)) / 64'(model_length);
                model_level = model_start_level + lrd_pkg::LEVEL_BITS'(stepped);
            end
            else
            begin
                span        = 64'(model_start_level - model_target);
                stepped     = (span * 64'(elapsed)) / 64'(model_length);
                model_level = model_start_level - lrd_pkg::LEVEL_BITS'(stepped);
            end
            res.done = 1'b0;
        end
        res.lvl = model_level;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input longint exp_val,
                                   input longint act_val);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("mismatch %0d at %0t: %s expected 0x%0h, got 0x%0h",
                     mismatches, $realtime, what, exp_val, act_val);
    endtask

    // offer one transaction, wait for it to be taken, record its expected level
    task automatic send_dim_cmd(input dim_cmd_t cmd);
        dim_level_t predicted;
        while (!no_gaps && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid     = 1'b1;
        kind         = cmd.kind;
        target_level = cmd.target;
        ramp_ms      = cmd.ramp;
        now_ms       = cmd.now;
        do
            @(posedge clk);
        while (!in_ready);
        predicted = next_dim_level(cmd);
        if (cmd.typed)
        begin
            predicted.lvl  = cmd.lvl;
            predicted.done = cmd.done;
        end
        expected_levels.push_back(predicted);
        items_sent++;
        if (cmd.kind == KIND_CLEAR)
            clears_sent++;
        @(negedge clk);
    endtask

    // well-formed ramp: new target, then steps through and past the ramp
    task automatic send_ramp_sequence();
        dim_cmd_t                      cmd;
        logic [lrd_pkg::TIME_BITS-1:0] t;
        logic [lrd_pkg::RAMP_BITS-1:0] len;
        int                            n;
        int                            sel;
        sel = $urandom_range(0, 99);
        if (sel < 70)
            len = lrd_pkg::RAMP_BITS'($urandom_range(1, 200));
        else if (sel < 80)
            len = '0;
        else if (sel < 90)
            len = lrd_pkg::RAMP_BITS'($urandom_range(200, 5000));
        else
            len = lrd_pkg::RAMP_BITS'($urandom);
        t = ($urandom_range(0, 9) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 3000)
                                         : $urandom;
        cmd.kind   = KIND_STEP;
        cmd.typed  = 1'b0;
        cmd.lvl    = '0;
        cmd.done   = 1'b0;
        cmd.target = lrd_pkg::LEVEL_BITS'($urandom);
        if (cmd.target == model_target)
            cmd.target = cmd.target ^ 16'h0001;
        cmd.ramp = len;
        cmd.now  = t;
        send_dim_cmd(cmd);
        n = $urandom_range(2, 8);
        for (int i = 0; i < n; i++)
        begin
            sel      = $urandom_range(0, 99);
            cmd.ramp = lrd_pkg::RAMP_BITS'($urandom);
            if (sel < 5)
                t = t - $urandom_range(1, 100);
            else if (sel < 15)
                t = t + lrd_pkg::TIME_BITS'(len);
            else
                t = t + $urandom_range(0, (len >> 2) + 2);
            cmd.now = t;
            send_dim_cmd(cmd);
        end
    endtask

    // stimulus
    initial
    begin
        dim_cmd_t cmd;
        int       sel;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        kind         = KIND_STEP;
        target_level = '0;
        ramp_ms      = '0;
        now_ms       = '0;
        mismatches   = 0;
        items_sent   = 0;
        clears_sent  = 0;
        no_gaps      = 1'b0;
        hold_request = 1'b0;
        clear_dimmer_state();

        ramp_script = '{
            '{KIND_STEP,  16'h0000, 24'd0,       32'd0,               1, 16'h0000, 0},
            '{KIND_STEP,  16'h0000, 24'd5,       32'd1000,            1, 16'h0000, 1},
            '{KIND_STEP,  16'hFFFF, 24'd0,       32'd5,               1, 16'hFFFF, 1},
            '{KIND_STEP,  16'h0000, 24'hFFFFFF,  32'd100,             0, 16'h0000, 0},
            '{KIND_STEP,  16'h0000, 24'd0,       32'd100 + 32'h7FFFFF, 0, 16'h0000, 0},
            '{KIND_STEP,  16'h0000, 24'd0,       32'd100 + 32'hFFFFFF, 1, 16'h0000, 1},
            '{KIND_CLEAR, 16'hFFFF, 24'hFFFFFF,  32'hFFFFFFFF,        1, 16'h0000, 0},
            '{KIND_STEP,  16'd1000, 24'd1000,    32'hFFFFFF00,        0, 16'h0000, 0},
            '{KIND_STEP,  16'd1000, 24'd77,      32'h000000F4,        0, 16'h0000, 0},
            '{KIND_STEP,  16'd1000, 24'd3,       32'h00000100,        0, 16'h0000, 0},
            '{KIND_STEP,  16'd1000, 24'd0,       32'hFFFFFE00,        0, 16'h0000, 0},
            '{KIND_STEP,  16'd200,  24'd10,      32'h00000010,        0, 16'h0000, 0},
            '{KIND_STEP,  16'd200,  24'd0,       32'h00000013,        0, 16'h0000, 0},
            '{KIND_STEP,  16'd5000, 24'd7,       32'h00000014,        0, 16'h0000, 0},
            '{KIND_STEP,  16'd5000, 24'd0,       32'h00000015,        0, 16'h0000, 0},
            '{KIND_STEP,  16'd5000, 24'd0,       32'h0000001B,        0, 16'h0000, 0},
            '{KIND_CLEAR, 16'h0000, 24'd0,       32'd0,               1, 16'h0000, 0},
            '{KIND_STEP,  16'h0000, 24'd0,       32'h00000500,        0, 16'h0000, 0},
            '{KIND_STEP,  16'hFFFF, 24'd1,       32'hFFFFFFFF,        0, 16'h0000, 0},
            '{KIND_STEP,  16'hFFFF, 24'd0,       32'd0,               1, 16'hFFFF, 1},
            '{KIND_STEP,  16'h0000, 24'd3,       32'd1,               0, 16'h0000, 0},
            '{KIND_STEP,  16'h0000, 24'd0,       32'd2,               0, 16'h0000, 0},
            '{KIND_STEP,  16'h0000, 24'd0,       32'd3,               0, 16'h0000, 0},
            '{KIND_STEP,  16'h0000, 24'd0,       32'd4,               1, 16'h0000, 1}
        };

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed part
        for (int i = 0; i < SCRIPT_ROWS; i++)
            send_dim_cmd(ramp_script[i]);

        // random part: mostly ramp sequences, some clears and noise
        while (items_sent < SCRIPT_ROWS + RANDOM_ITEMS)
        begin
            if (items_sent >= SCRIPT_ROWS + 150 && items_sent < SCRIPT_ROWS + 160)
                hold_request = 1'b1;
            no_gaps = (items_sent >= SCRIPT_ROWS + 300 && items_sent < SCRIPT_ROWS + 400);
            sel = $urandom_range(0, 99);
            if (sel < 8)
            begin
                cmd.kind   = KIND_CLEAR;
                cmd.target = lrd_pkg::LEVEL_BITS'($urandom);
                cmd.ramp   = lrd_pkg::RAMP_BITS'($urandom);
                cmd.now    = $urandom;
                cmd.typed  = 1'b0;
                send_dim_cmd(cmd);
            end
            else if (sel < 18)
            begin
                cmd.kind   = KIND_STEP;
                cmd.target = lrd_pkg::LEVEL_BITS'($urandom);
                cmd.ramp   = lrd_pkg::RAMP_BITS'($urandom);
                cmd.now    = $urandom;
                cmd.typed  = 1'b0;
                send_dim_cmd(cmd);
            end
            else
                send_ramp_sequence();
        end
        in_valid = 1'b0;
        no_gaps  = 1'b0;

        // drain, then allow the longest step to settle
        while (expected_levels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d transactions (%0d clears): %0d levels mid-ramp, %0d at target",
                 items_sent, clears_sent, ramping_seen, finished_seen);
        $display("zero and full-length ramps, time wrap and backward time, output hold-off");
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // result receiver with random stalls and long hold-offs on hold_request
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_ready    = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            out_ready = no_gaps ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // result check and watchdog
    always @(posedge clk)
    begin
        dim_level_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                levels_seen++;
                if (ramp_done)
                    finished_seen++;
                else
                    ramping_seen++;
                if (expected_levels.size() == 0)
                    report_mismatch("unexpected transaction, level", 0, level);
                else
                begin
                    want = expected_levels.pop_front();
                    if (level !== want.lvl)
                        report_mismatch("level", want.lvl, level);
                    if (ramp_done !== want.done)
                        report_mismatch("ramp_done", want.done, ramp_done);
                end
            end
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no transaction for %0d cycles, %0d levels pending",
                         quiet_cycles, expected_levels.size());
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    initial
    begin
        levels_seen   = 0;
        finished_seen = 0;
        ramping_seen  = 0;
        quiet_cycles  = 0;
    end

endmodule
